FILE: design/plfe_pkg.sv
// ----------------------------------------------------------------------------
// plfe_pkg
// Shared types and constants for the linear PWM fade engine: payload
// structs, opcodes and the controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package plfe_pkg;

   // opcodes of an input beat
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_FADE = 1'b1;

   localparam int unsigned LEVEL_W = 8;
   localparam int unsigned TIME_W  = 16;
   localparam int unsigned NEXT_W  = 17;
   localparam int unsigned PROD_W  = LEVEL_W + TIME_W;
   localparam int unsigned STEP_W  = 3;

   localparam logic [TIME_W-1:0] INTERVAL_RESET = 16'd20;

   // input beat
   typedef struct packed {
      logic              op;
      logic [LEVEL_W-1:0] target_level;
      logic [TIME_W-1:0]  fade_time;
   } plfe_req_type;

   // result beat
   typedef struct packed {
      logic [LEVEL_W-1:0] duty;
      logic               duty_written;
      logic               fading;
   } plfe_rsp_type;

   // controller to datapath
   typedef struct packed {
      logic              load;      // take the accepted beat, update fade state
      logic              mul;       // form |goal-start| * elapsed
      logic              div_step;  // one restoring divide step
      logic              div_last;  // final step: commit interpolated level
      logic [STEP_W-1:0] step;      // quotient bit of this step
      logic              out_load;  // move result into output register
   } plfe_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic interp;                 // accepted tick needs an interpolated level
   } plfe_sts_type;

endpackage

`default_nettype wire

FILE: design/plfe_dp.sv
// ----------------------------------------------------------------------------
// plfe_dp
// Fade datapath: level and timing state, update-interval register,
// multiplier stage, bit-per-cycle restoring divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module plfe_dp (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          csr_we,
   input  wire  [15:0]                  csr_wdata,
   input  wire  plfe_pkg::plfe_req_type req_data,
   input  wire  plfe_pkg::plfe_cmd_type cmd,
   output       plfe_pkg::plfe_sts_type sts,
   output       plfe_pkg::plfe_rsp_type rsp_data
);
   import plfe_pkg::*;

   // architectural fade state
   logic [TIME_W-1:0]  interval_ff;
   logic [LEVEL_W-1:0] current_ff,  current_in;
   logic [LEVEL_W-1:0] start_ff,    start_in;
   logic [LEVEL_W-1:0] goal_ff,     goal_in;
   logic [TIME_W-1:0]  elapsed_ff,  elapsed_in;
   logic [TIME_W-1:0]  length_ff,   length_in;
   logic [NEXT_W-1:0]  next_at_ff,  next_at_in;
   logic               active_ff,   active_in;
   logic               written_ff,  written_in;

   // arithmetic working registers
   logic               neg_ff;
   logic [PROD_W-1:0]  rem_ff,  rem_in;
   logic [LEVEL_W-1:0] quot_ff, quot_in;
   plfe_rsp_type       rsp_ff;

   // tick evaluation
   logic [TIME_W-1:0]  elapsed_nx;
   logic               snap;
   logic               interp;
   logic               neg;
   logic [LEVEL_W-1:0] mag;
   logic [PROD_W-1:0]  div_sh;
   logic [LEVEL_W-1:0] q_signed;

   assign elapsed_nx = elapsed_ff + TIME_W'(1);
   assign snap       = (elapsed_nx >= length_ff);
   assign interp     = !snap && ({1'b0, elapsed_nx} > next_at_ff);
   assign sts.interp = (req_data.op == OP_TICK) && active_ff && interp;

   // sign and magnitude of goal - start
   assign neg = (goal_ff < start_ff);
   assign mag = neg ? (start_ff - goal_ff) : (goal_ff - start_ff);

   // divisor aligned to the current quotient bit
   assign div_sh = {{LEVEL_W{1'b0}}, length_ff} << cmd.step;

   // divide step and level commit
   always_comb begin
      rem_in  = rem_ff;
      quot_in = quot_ff;
      if (rem_ff >= div_sh) begin
         rem_in  = rem_ff - div_sh;
         quot_in = {quot_ff[LEVEL_W-2:0], 1'b1};
      end else begin
         quot_in = {quot_ff[LEVEL_W-2:0], 1'b0};
      end
   end

   // truncation toward zero: negate the magnitude quotient
   assign q_signed = neg_ff ? (~quot_in + LEVEL_W'(1)) : quot_in;

   // fade state update
   always_comb begin
      current_in = current_ff;
      start_in   = start_ff;
      goal_in    = goal_ff;
      elapsed_in = elapsed_ff;
      length_in  = length_ff;
      next_at_in = next_at_ff;
      active_in  = active_ff;
      written_in = written_ff;
      if (cmd.load) begin
         written_in = 1'b0;
         if (req_data.op == OP_FADE) begin
            start_in   = current_ff;
            goal_in    = req_data.target_level;
            length_in  = req_data.fade_time;
            elapsed_in = '0;
            next_at_in = {1'b0, interval_ff};
            active_in  = 1'b1;
         end else if (active_ff) begin
            elapsed_in = elapsed_nx;
            if (snap) begin
               active_in  = 1'b0;
               current_in = goal_ff;
               written_in = 1'b1;
            end else if (interp) begin
               next_at_in = next_at_ff + {1'b0, interval_ff};
               written_in = 1'b1;
            end
         end
      end else if (cmd.div_last) begin
         current_in = start_ff + q_signed;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= INTERVAL_RESET;
         current_ff  <= '0;
         start_ff    <= '0;
         goal_ff     <= '0;
         elapsed_ff  <= '0;
         length_ff   <= '0;
         next_at_ff  <= '0;
         active_ff   <= 1'b0;
         written_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            interval_ff <= csr_wdata;
         end
         current_ff <= current_in;
         start_ff   <= start_in;
         goal_ff    <= goal_in;
         elapsed_ff <= elapsed_in;
         length_ff  <= length_in;
         next_at_ff <= next_at_in;
         active_ff  <= active_in;
         written_ff <= written_in;
      end
   end

   // multiplier, divider and result registers
   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         rem_ff  <= PROD_W'(mag) * PROD_W'(elapsed_ff);
         neg_ff  <= neg;
         quot_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
      end
      if (cmd.out_load) begin
         rsp_ff.duty         <= current_ff;
         rsp_ff.duty_written <= written_ff;
         rsp_ff.fading       <= active_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

FILE: design/plfe_ctrl.sv
// ----------------------------------------------------------------------------
// plfe_ctrl
// Sequencer for the fade engine: accepts one beat at a time, runs the
// multiply and divide steps when a tick needs an interpolated level,
// and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module plfe_ctrl (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   input  wire  plfe_pkg::plfe_sts_type sts,
   output       plfe_pkg::plfe_cmd_type cmd
);
   import plfe_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff,  step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;
   logic              out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.step     = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               state_in = sts.interp ? ST_MUL : ST_DONE;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            step_in  = {STEP_W{1'b1}};
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               cmd.div_last = 1'b1;
               state_in     = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // a loaded result is presented on the next cycle
   a_out_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("result loaded but not presented");

   // a tick that needs interpolation goes to the multiplier
   a_interp_mul: assert property (@(posedge clock) disable iff (reset)
      (accept && sts.interp) |=> (state_ff == ST_MUL))
      else $error("interpolating tick skipped multiply");

   // the divider ends after the last quotient bit
   a_div_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && step_ff == '0) |=> (state_ff == ST_DONE))
      else $error("divider overran its last step");

   // a pending result is never overwritten while stalled
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> out_free)
      else $error("result register overwritten");

endmodule

`default_nettype wire

FILE: design/pwm_linear_fade_engine.sv
// ----------------------------------------------------------------------------
// pwm_linear_fade_engine
// Linear brightness fade for one PWM channel, built as a sequencer and
// a datapath with a registered result beat.
// ----------------------------------------------------------------------------
// Each request beat is either a fade start (op = 1) or a one-millisecond
// tick (op = 0) and yields exactly one result beat carrying the duty level,
// a flag telling whether this beat changed it, and the fading flag. The
// engine works on one beat at a time: a fade start, an idle tick or a tick
// that ends the fade goes from accept to result load; a tick that lands an
// intermediate update runs accept, one multiply, eight restoring divide
// steps (one bit per cycle) and result load. A result waiting in the
// output register delays the next one until it is taken. The update
// interval register (reset value 20 ms) is to be written by the user via
// csr_we / csr_wdata only while the engine is idle, which is not enforced.
`default_nettype none

module pwm_linear_fade_engine (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          csr_we,
   input  wire  [15:0]                  csr_wdata,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire  plfe_pkg::plfe_req_type req_data,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output       plfe_pkg::plfe_rsp_type rsp_data
);
   import plfe_pkg::*;

   plfe_cmd_type cmd;
   plfe_sts_type sts;

   // sequencer
   plfe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath
   plfe_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
